### rtl/i2cee_pkg.sv
// Package: word types, op codes, register indexes and the transaction sequence table.
package i2cee_pkg;

    // Op codes of an input word
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_READ_RECOV  = 2'd0;
    localparam logic [1:0] REG_WRITE_RECOV = 2'd1;

    // Reset values of the configuration registers
    localparam logic [15:0] READ_RECOV_RESET  = 16'd100;
    localparam logic [15:0] WRITE_RECOV_RESET = 16'd5000;

    // Device address bytes and the ack poll limit
    localparam logic [7:0] DEV_ADDR_W   = 8'hA0;
    localparam logic [7:0] DEV_ADDR_R   = 8'hA1;
    localparam logic [7:0] ACK_POLL_MAX = 8'd255;

    // Phase kinds, one-hot
    typedef enum logic [9:0] {
        K_NONE  = 10'b00_0000_0001,
        K_START = 10'b00_0000_0010,
        K_DEV_W = 10'b00_0000_0100,
        K_DEV_R = 10'b00_0000_1000,
        K_ADDR  = 10'b00_0001_0000,
        K_DATA  = 10'b00_0010_0000,
        K_ACK   = 10'b00_0100_0000,
        K_READ  = 10'b00_1000_0000,
        K_STOP  = 10'b01_0000_0000,
        K_RECOV = 10'b10_0000_0000
    } t_kind;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] mem_address;
        logic [7:0] write_data;
        logic       sda_in;
    } t_in_word;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       rejected;
    } t_out_word;

    // Kind of the phase at a sequence position
    function automatic t_kind kind_at(input logic is_wr, input logic [3:0] pos);
        t_kind k;
        k = K_NONE;
        if (is_wr) begin
            unique case (pos)
                4'd0:    k = K_START;
                4'd1:    k = K_DEV_W;
                4'd2:    k = K_ACK;
                4'd3:    k = K_ADDR;
                4'd4:    k = K_ACK;
                4'd5:    k = K_DATA;
                4'd6:    k = K_ACK;
                4'd7:    k = K_STOP;
                4'd8:    k = K_RECOV;
                default: k = K_NONE;
            endcase
        end else begin
            unique case (pos)
                4'd0:    k = K_START;
                4'd1:    k = K_DEV_W;
                4'd2:    k = K_ACK;
                4'd3:    k = K_ADDR;
                4'd4:    k = K_ACK;
                4'd5:    k = K_START;
                4'd6:    k = K_DEV_R;
                4'd7:    k = K_ACK;
                4'd8:    k = K_READ;
                4'd9:    k = K_STOP;
                4'd10:   k = K_RECOV;
                default: k = K_NONE;
            endcase
        end
        return k;
    endfunction

endpackage

### rtl/i2cee_core.sv
// Bus sequencer: transaction state, one update per accepted input word.
module i2cee_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  i2cee_pkg::t_in_word  i_word,
    input  logic [15:0]          i_read_recov,
    input  logic [15:0]          i_write_recov,
    output i2cee_pkg::t_out_word o_result
);

    logic [3:0]  r_phase,     n_phase;
    logic [2:0]  r_sub,       n_sub;
    logic [3:0]  r_bits,      n_bits;
    logic [7:0]  r_shift,     n_shift;
    logic [7:0]  r_ack_cnt,   n_ack_cnt;
    logic [15:0] r_recov,     n_recov;
    logic [7:0]  r_addr,      n_addr;
    logic [7:0]  r_data,      n_data;
    logic        r_is_write,  n_is_write;
    logic        r_scl,       n_scl;
    logic        r_sda,       n_sda;
    logic [7:0]  r_last_read, n_last_read;

    i2cee_pkg::t_kind cur_kind;
    i2cee_pkg::t_kind nxt_kind;
    logic             enter;
    logic [3:0]       enter_pos;
    logic             done;
    logic             rej;
    logic [3:0]       bits_inc;
    logic [7:0]       shift_in;
    logic [15:0]      recov_dec;

    assign cur_kind  = i2cee_pkg::kind_at(r_is_write, r_phase - 4'd1);
    assign bits_inc  = r_bits + 4'd1;
    assign shift_in  = {r_shift[6:0], i_word.sda_in};
    assign recov_dec = (r_recov != 16'd0) ? r_recov - 16'd1 : r_recov;

    // Next state for one word
    always_comb begin
        n_phase     = r_phase;
        n_sub       = r_sub;
        n_bits      = r_bits;
        n_shift     = r_shift;
        n_ack_cnt   = r_ack_cnt;
        n_recov     = r_recov;
        n_addr      = r_addr;
        n_data      = r_data;
        n_is_write  = r_is_write;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_last_read = r_last_read;
        nxt_kind    = i2cee_pkg::K_NONE;
        enter       = 1'b0;
        enter_pos   = r_phase;
        done        = 1'b0;
        rej         = 1'b0;

        if (i_word.op == i2cee_pkg::OP_READ || i_word.op == i2cee_pkg::OP_WRITE) begin
            if (r_phase != 4'd0) begin
                rej = 1'b1;
            end else begin
                n_addr     = i_word.mem_address;
                n_data     = i_word.write_data;
                n_is_write = (i_word.op == i2cee_pkg::OP_WRITE);
                enter      = 1'b1;
                enter_pos  = 4'd0;
            end
        end else if (i_word.op == i2cee_pkg::OP_TICK && r_phase != 4'd0) begin
            unique case (cur_kind)
                i2cee_pkg::K_START: begin
                    unique case (r_sub)
                        3'd0:    n_sda = 1'b1;
                        3'd1:    n_scl = 1'b1;
                        3'd2:    n_sda = 1'b0;
                        default: begin
                            n_scl = 1'b0;
                            enter = 1'b1;
                        end
                    endcase
                    n_sub = r_sub + 3'd1;
                end
                i2cee_pkg::K_DEV_W, i2cee_pkg::K_DEV_R,
                i2cee_pkg::K_ADDR, i2cee_pkg::K_DATA: begin
                    unique case (r_sub)
                        3'd0: begin
                            n_scl = 1'b0;
                            n_sub = 3'd1;
                        end
                        3'd1: begin
                            n_sda   = r_shift[7];
                            n_shift = {r_shift[6:0], 1'b0};
                            n_sub   = 3'd2;
                        end
                        3'd2: begin
                            n_scl  = 1'b1;
                            n_bits = bits_inc;
                            n_sub  = (bits_inc >= 4'd8) ? 3'd3 : 3'd0;
                        end
                        3'd3: begin
                            n_scl = 1'b0;
                            n_sub = 3'd4;
                        end
                        default: begin
                            n_sda = 1'b1;
                            enter = 1'b1;
                        end
                    endcase
                end
                i2cee_pkg::K_ACK: begin
                    if (r_sub == 3'd0) begin
                        n_scl     = 1'b1;
                        n_ack_cnt = 8'd0;
                        n_sub     = 3'd1;
                    end else if (i_word.sda_in && r_ack_cnt < i2cee_pkg::ACK_POLL_MAX) begin
                        n_ack_cnt = r_ack_cnt + 8'd1;
                    end else begin
                        n_scl = 1'b0;
                        enter = 1'b1;
                    end
                end
                i2cee_pkg::K_READ: begin
                    unique case (r_sub)
                        3'd0: begin
                            n_scl = 1'b0;
                            n_sub = 3'd1;
                        end
                        3'd1: begin
                            n_sda   = 1'b1;
                            n_shift = 8'd0;
                            n_sub   = 3'd2;
                        end
                        3'd2: begin
                            n_scl = 1'b1;
                            n_sub = 3'd3;
                        end
                        default: begin
                            n_shift = shift_in;
                            n_scl   = 1'b0;
                            n_bits  = bits_inc;
                            if (bits_inc >= 4'd8) begin
                                n_last_read = shift_in;
                                enter       = 1'b1;
                            end else begin
                                n_sub = 3'd2;
                            end
                        end
                    endcase
                end
                i2cee_pkg::K_STOP: begin
                    unique case (r_sub)
                        3'd0: begin
                            n_sda = 1'b0;
                            n_sub = 3'd1;
                        end
                        3'd1: begin
                            n_scl = 1'b1;
                            n_sub = 3'd2;
                        end
                        default: begin
                            n_sda   = 1'b1;
                            n_recov = r_is_write ? i_write_recov : i_read_recov;
                            if (n_recov == 16'd0) begin
                                n_phase = 4'd0;
                                done    = 1'b1;
                            end else begin
                                enter = 1'b1;
                            end
                        end
                    endcase
                end
                i2cee_pkg::K_RECOV: begin
                    n_recov = recov_dec;
                    if (recov_dec == 16'd0) begin
                        n_phase = 4'd0;
                        done    = 1'b1;
                    end
                end
                default: n_phase = 4'd0;
            endcase
        end

        // Enter the next phase of the sequence
        if (enter) begin
            nxt_kind = i2cee_pkg::kind_at(n_is_write, enter_pos);
            if (nxt_kind == i2cee_pkg::K_NONE) begin
                n_phase = 4'd0;
            end else begin
                n_phase   = enter_pos + 4'd1;
                n_sub     = 3'd0;
                n_bits    = 4'd0;
                n_ack_cnt = 8'd0;
                unique case (nxt_kind)
                    i2cee_pkg::K_DEV_W: n_shift = i2cee_pkg::DEV_ADDR_W;
                    i2cee_pkg::K_DEV_R: n_shift = i2cee_pkg::DEV_ADDR_R;
                    i2cee_pkg::K_ADDR:  n_shift = n_addr;
                    i2cee_pkg::K_DATA:  n_shift = n_data;
                    default:            n_shift = n_shift;
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 4'd0;
            r_sub       <= 3'd0;
            r_bits      <= 4'd0;
            r_shift     <= 8'd0;
            r_ack_cnt   <= 8'd0;
            r_recov     <= 16'd0;
            r_addr      <= 8'd0;
            r_data      <= 8'd0;
            r_is_write  <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_last_read <= 8'd0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_sub       <= n_sub;
            r_bits      <= n_bits;
            r_shift     <= n_shift;
            r_ack_cnt   <= n_ack_cnt;
            r_recov     <= n_recov;
            r_addr      <= n_addr;
            r_data      <= n_data;
            r_is_write  <= n_is_write;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_last_read <= n_last_read;
        end
    end

    // Result word for this input word
    always_comb begin
        o_result.scl_out   = n_scl;
        o_result.sda_out   = n_sda;
        o_result.busy_res  = (n_phase != 4'd0);
        o_result.done_res  = done;
        o_result.read_data = n_last_read;
        o_result.rejected  = rej;
    end

endmodule

### rtl/i2c_eeprom_byte_access_master.sv
// Top level: I2C EEPROM byte write / random read master with word handshakes.
//
//  channel   signals                               width  role
//  in        i_in_valid / o_in_ready / i_in_word     19    request or bus tick
//  out       o_out_valid / i_out_ready / o_out_word  13    line levels and status
//  cfg       i_cfg_we / i_cfg_index / i_cfg_data     16    recovery tick counts
//
// Each input word is handled combinationally; its result word appears in the output
// register on the next cycle. Sustained rate is one word per cycle without output stall,
// set by the single output register that is refilled in the same cycle it is taken.
// Stall on the output holds the result and blocks input until it is taken.
// Reset is synchronous: bus idle, both lines released, recovery counts 100/5000.
module i2c_eeprom_byte_access_master (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  i2cee_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output i2cee_pkg::t_out_word o_out_word,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    logic [15:0]          r_read_recov;
    logic [15:0]          r_write_recov;
    logic                 r_out_valid;
    i2cee_pkg::t_out_word r_out_word;
    i2cee_pkg::t_out_word result;
    logic                 step;

    // Accept when the output register is empty or being emptied
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign step       = i_in_valid && o_in_ready;

    i2cee_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_word        (i_in_word),
        .i_read_recov  (r_read_recov),
        .i_write_recov (r_write_recov),
        .o_result      (result)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_recov  <= i2cee_pkg::READ_RECOV_RESET;
            r_write_recov <= i2cee_pkg::WRITE_RECOV_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == i2cee_pkg::REG_READ_RECOV) begin
                r_read_recov <= i_cfg_data;
            end else if (i_cfg_index == i2cee_pkg::REG_WRITE_RECOV) begin
                r_write_recov <= i_cfg_data;
            end
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### verif/tb_i2c_eeprom_byte_access_master.sv
// Testbench for the I2C EEPROM byte write / random read master, with its own bus predictor.
module tb_i2c_eeprom_byte_access_master;
    timeunit 1ns;
    timeprecision 1ps;

    // Codes the package leaves unnamed
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0] REG_SPARE_2 = 2'd2;
    localparam logic [1:0] REG_SPARE_3 = 2'd3;

    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    localparam int unsigned PHASE_ITEMS    = 400;
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned FIRST_ACK_POS1 = 3;

    // Result words that can be read straight off the spec
    localparam i2cee_pkg::t_out_word LINES_IDLE = '{scl_out: 1'b1, sda_out: 1'b1,
        busy_res: 1'b0, done_res: 1'b0, read_data: 8'h00, rejected: 1'b0};
    localparam i2cee_pkg::t_out_word JUST_STARTED = '{scl_out: 1'b1, sda_out: 1'b1,
        busy_res: 1'b1, done_res: 1'b0, read_data: 8'h00, rejected: 1'b0};
    localparam i2cee_pkg::t_out_word BUSY_REJECT = '{scl_out: 1'b1, sda_out: 1'b1,
        busy_res: 1'b1, done_res: 1'b0, read_data: 8'h00, rejected: 1'b1};

    // DUT ports
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    i2cee_pkg::t_in_word  i_in_word   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    i2cee_pkg::t_out_word o_out_word;
    logic                 i_cfg_we    = 1'b0;
    logic [1:0]           i_cfg_index = '0;
    logic [15:0]          i_cfg_data  = '0;

    i2c_eeprom_byte_access_master u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Directed stimulus row: either a register write or an input word
    typedef struct packed {
        bit                   is_cfg;
        logic [1:0]           cfg_idx;
        logic [15:0]          cfg_val;
        i2cee_pkg::t_in_word  word;
        bit                   typed;
        i2cee_pkg::t_out_word want;
    } t_stim_row;

    t_stim_row            stim_rows[$];
    i2cee_pkg::t_out_word pending_levels[$];
    i2cee_pkg::t_out_word want_word;
    i2cee_pkg::t_out_word row_want;
    int unsigned mismatch_count = 0;
    int unsigned words_checked  = 0;
    int unsigned items_sent     = 0;
    int unsigned cycle_count    = 0;
    int unsigned tx_idle_pct    = 0;
    int unsigned rx_idle_pct    = 0;
    int unsigned rx_hold_left   = 0;

    // Transaction plans, one phase kind per sequence position
    i2cee_pkg::t_kind wr_sequence [9]  = '{i2cee_pkg::K_START, i2cee_pkg::K_DEV_W,
        i2cee_pkg::K_ACK, i2cee_pkg::K_ADDR, i2cee_pkg::K_ACK, i2cee_pkg::K_DATA,
        i2cee_pkg::K_ACK, i2cee_pkg::K_STOP, i2cee_pkg::K_RECOV};
    i2cee_pkg::t_kind rd_sequence [11] = '{i2cee_pkg::K_START, i2cee_pkg::K_DEV_W,
        i2cee_pkg::K_ACK, i2cee_pkg::K_ADDR, i2cee_pkg::K_ACK, i2cee_pkg::K_START,
        i2cee_pkg::K_DEV_R, i2cee_pkg::K_ACK, i2cee_pkg::K_READ, i2cee_pkg::K_STOP,
        i2cee_pkg::K_RECOV};

    // Predicted master state (reset values)
    int unsigned seq_pos1      = 0;     // 0 idle, else sequence position + 1
    int unsigned phase_step    = 0;
    logic [3:0]  bits_done     = '0;
    logic [7:0]  shifter       = '0;
    logic [7:0]  ack_polls     = '0;
    logic [15:0] recov_left    = '0;
    logic [7:0]  req_addr      = '0;
    logic [7:0]  req_data      = '0;
    logic        req_is_wr     = 1'b0;
    logic        scl_level     = 1'b1;
    logic        sda_level     = 1'b1;
    logic [7:0]  last_rx_byte  = '0;
    logic [15:0] rd_recov_cfg  = i2cee_pkg::READ_RECOV_RESET;
    logic [15:0] wr_recov_cfg  = i2cee_pkg::WRITE_RECOV_RESET;

    function automatic i2cee_pkg::t_kind kind_of(input int unsigned pos);
        if (req_is_wr) return (pos < 9) ? wr_sequence[pos] : i2cee_pkg::K_NONE;
        return (pos < 11) ? rd_sequence[pos] : i2cee_pkg::K_NONE;
    endfunction

    // Move to a sequence position, loading the byte to shift out
    function automatic void enter_phase(input int unsigned pos);
        i2cee_pkg::t_kind k;
        k = kind_of(pos);
        if (k == i2cee_pkg::K_NONE) begin
            seq_pos1 = 0;
            return;
        end
        seq_pos1   = pos + 1;
        phase_step = 0;
        bits_done  = '0;
        ack_polls  = '0;
        case (k)
            i2cee_pkg::K_DEV_W: shifter = i2cee_pkg::DEV_ADDR_W;
            i2cee_pkg::K_DEV_R: shifter = i2cee_pkg::DEV_ADDR_R;
            i2cee_pkg::K_ADDR:  shifter = req_addr;
            i2cee_pkg::K_DATA:  shifter = req_data;
            default: ;
        endcase
    endfunction

    // One bus phase step; returns 1 when the transaction including recovery ends
    function automatic bit bus_tick(input logic sda_s);
        int unsigned pos;
        bit          fin;
        bit          done;
        pos  = seq_pos1 - 1;
        fin  = 1'b0;
        done = 1'b0;
        case (kind_of(pos))
            i2cee_pkg::K_START: begin
                case (phase_step)
                    0:       sda_level = 1'b1;
                    1:       scl_level = 1'b1;
                    2:       sda_level = 1'b0;
                    default: begin
                        scl_level = 1'b0;
                        fin = 1'b1;
                    end
                endcase
                phase_step++;
            end
            i2cee_pkg::K_DEV_W, i2cee_pkg::K_DEV_R, i2cee_pkg::K_ADDR,
            i2cee_pkg::K_DATA: begin
                if (phase_step == 0) begin
                    scl_level  = 1'b0;
                    phase_step = 1;
                end else if (phase_step == 1) begin
                    sda_level  = shifter[7];
                    shifter    = {shifter[6:0], 1'b0};
                    phase_step = 2;
                end else if (phase_step == 2) begin
                    scl_level  = 1'b1;
                    bits_done  = bits_done + 4'd1;
                    phase_step = (bits_done >= 4'd8) ? 3 : 0;
                end else if (phase_step == 3) begin
                    scl_level  = 1'b0;
                    phase_step = 4;
                end else begin
                    sda_level = 1'b1;
                    fin = 1'b1;
                end
            end
            i2cee_pkg::K_ACK: begin
                // clock high, then poll until the slave pulls low or the poll limit
                if (phase_step == 0) begin
                    scl_level  = 1'b1;
                    ack_polls  = '0;
                    phase_step = 1;
                end else if (sda_s && ack_polls < i2cee_pkg::ACK_POLL_MAX) begin
                    ack_polls = ack_polls + 8'd1;
                end else begin
                    scl_level = 1'b0;
                    fin = 1'b1;
                end
            end
            i2cee_pkg::K_READ: begin
                if (phase_step == 0) begin
                    scl_level  = 1'b0;
                    phase_step = 1;
                end else if (phase_step == 1) begin
                    sda_level  = 1'b1;
                    shifter    = '0;
                    phase_step = 2;
                end else if (phase_step == 2) begin
                    scl_level  = 1'b1;
                    phase_step = 3;
                end else begin
                    shifter   = {shifter[6:0], sda_s};
                    scl_level = 1'b0;
                    bits_done = bits_done + 4'd1;
                    if (bits_done >= 4'd8) begin
                        last_rx_byte = shifter;
                        fin = 1'b1;
                    end else begin
                        phase_step = 2;
                    end
                end
            end
            i2cee_pkg::K_STOP: begin
                if (phase_step == 0) begin
                    sda_level  = 1'b0;
                    phase_step = 1;
                end else if (phase_step == 1) begin
                    scl_level  = 1'b1;
                    phase_step = 2;
                end else begin
                    // recovery count is taken from the registers at this point
                    sda_level  = 1'b1;
                    recov_left = req_is_wr ? wr_recov_cfg : rd_recov_cfg;
                    if (recov_left == 16'd0) begin
                        seq_pos1 = 0;
                        done = 1'b1;
                    end else begin
                        fin = 1'b1;
                    end
                end
            end
            i2cee_pkg::K_RECOV: begin
                if (recov_left != 16'd0) recov_left = recov_left - 16'd1;
                if (recov_left == 16'd0) begin
                    seq_pos1 = 0;
                    done = 1'b1;
                end
            end
            default: seq_pos1 = 0;
        endcase
        if (fin) enter_phase(pos + 1);
        return done;
    endfunction

    // Predicted result word for one accepted input word
    function automatic i2cee_pkg::t_out_word advance_master(input i2cee_pkg::t_in_word w);
        i2cee_pkg::t_out_word r;
        bit                   done;
        bit                   rej;
        done = 1'b0;
        rej  = 1'b0;
        if (w.op == i2cee_pkg::OP_READ || w.op == i2cee_pkg::OP_WRITE) begin
            if (seq_pos1 != 0) begin
                rej = 1'b1;
            end else begin
                req_addr  = w.mem_address;
                req_data  = w.write_data;
                req_is_wr = (w.op == i2cee_pkg::OP_WRITE);
                enter_phase(0);
            end
        end else if (w.op == i2cee_pkg::OP_TICK && seq_pos1 != 0) begin
            done = bus_tick(w.sda_in);
        end
        r.scl_out   = scl_level;
        r.sda_out   = sda_level;
        r.busy_res  = (seq_pos1 != 0);
        r.done_res  = done;
        r.read_data = last_rx_byte;
        r.rejected  = rej;
        return r;
    endfunction

    function automatic logic [15:0] pick_recov();
        return ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
    endfunction

    function automatic void add_word_row(input logic [1:0] op, input logic [7:0] addr,
                                         input logic [7:0] data, input logic sda,
                                         input bit typed,
                                         input i2cee_pkg::t_out_word want);
        t_stim_row r;
        r        = '0;
        r.word   = '{op: op, mem_address: addr, write_data: data, sda_in: sda};
        r.typed  = typed;
        r.want   = want;
        stim_rows.push_back(r);
    endfunction

    function automatic void add_cfg_row(input logic [1:0] idx, input logic [15:0] val);
        t_stim_row r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        stim_rows.push_back(r);
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatch_count++;
        $display("mismatch at result word %0d, %s: got 0x%0h, want 0x%0h",
                 words_checked, field, got, want);
    endtask

    // Offer one input word and wait until it is taken; also ends a register write
    task automatic send_word(input i2cee_pkg::t_in_word w);
        i_cfg_we <= 1'b0;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic issue(input i2cee_pkg::t_in_word w);
        send_word(w);
        pending_levels.push_back(advance_master(w));
        items_sent++;
    endtask

    // Sender stops until every pending result word has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
    endtask

    // Register write; the strobe stays up until the next word is offered
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx == i2cee_pkg::REG_READ_RECOV) rd_recov_cfg = val;
        else if (idx == i2cee_pkg::REG_WRITE_RECOV) wr_recov_cfg = val;
    endtask

    // Tick the bus until the transaction ends, with noise words mixed in
    task automatic drive_ticks(input bit nack, input bit retune);
        i2cee_pkg::t_in_word w;
        bit                  retuned;
        retuned = 1'b0;
        while (seq_pos1 != 0) begin
            w.op          = i2cee_pkg::OP_TICK;
            w.mem_address = 8'($urandom);
            w.write_data  = 8'($urandom);
            w.sda_in      = 1'($urandom);
            // with nack the first ack stays unanswered up to the poll limit
            if (kind_of(seq_pos1 - 1) == i2cee_pkg::K_ACK)
                w.sda_in = (nack && seq_pos1 == FIRST_ACK_POS1) ? 1'b1 :
                           ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 99))
                0, 1:    w.op = OP_UNUSED;
                2, 3:    w.op = $urandom_range(0, 1) ? i2cee_pkg::OP_READ
                                                     : i2cee_pkg::OP_WRITE;
                default: ;
            endcase
            // register change in mid transaction, picked up at the next stop
            if (retune && !retuned && $urandom_range(0, 49) == 0) begin
                retuned = 1'b1;
                write_reg($urandom_range(0, 1) ? i2cee_pkg::REG_READ_RECOV
                                               : i2cee_pkg::REG_WRITE_RECOV,
                          pick_recov());
            end
            issue(w);
        end
    endtask

    task automatic run_transfer(input logic [1:0] op, input bit nack, input bit retune);
        i2cee_pkg::t_in_word w;
        if ($urandom_range(0, 4) == 0) begin
            // filler while the bus is idle
            w.op          = $urandom_range(0, 1) ? i2cee_pkg::OP_TICK : OP_UNUSED;
            w.mem_address = 8'($urandom);
            w.write_data  = 8'($urandom);
            w.sda_in      = 1'($urandom);
            issue(w);
        end
        w.op          = op;
        w.mem_address = 8'($urandom);
        w.write_data  = 8'($urandom);
        w.sda_in      = 1'($urandom);
        issue(w);
        drive_ticks(nack, retune);
    endtask

    task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct);
        int unsigned first_item;
        int unsigned n_xfer;
        write_reg(i2cee_pkg::REG_READ_RECOV, pick_recov());
        write_reg(i2cee_pkg::REG_WRITE_RECOV, pick_recov());
        tx_idle_pct  = tx_pct;
        rx_idle_pct  = rx_pct;
        rx_hold_left = LONG_HOLD;
        first_item   = items_sent;
        n_xfer       = 0;
        while (items_sent - first_item < PHASE_ITEMS) begin
            if (n_xfer % 8 == 7) begin
                write_reg(i2cee_pkg::REG_READ_RECOV, pick_recov());
                write_reg(i2cee_pkg::REG_WRITE_RECOV, pick_recov());
            end
            run_transfer($urandom_range(0, 1) ? i2cee_pkg::OP_WRITE : i2cee_pkg::OP_READ,
                         n_xfer == 1, 1'b1);
            n_xfer++;
        end
    endtask

    // Clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                i_out_ready <= 1'b0;
                rx_hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Result check against the oldest pending word
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            words_checked++;
            if (pending_levels.size() == 0) begin
                report_mismatch("word with nothing pending", int'(o_out_word), 0);
            end else begin
                want_word = pending_levels.pop_front();
                if (o_out_word.scl_out !== want_word.scl_out)
                    report_mismatch("scl_out", o_out_word.scl_out, want_word.scl_out);
                if (o_out_word.sda_out !== want_word.sda_out)
                    report_mismatch("sda_out", o_out_word.sda_out, want_word.sda_out);
                if (o_out_word.busy_res !== want_word.busy_res)
                    report_mismatch("busy_res", o_out_word.busy_res, want_word.busy_res);
                if (o_out_word.done_res !== want_word.done_res)
                    report_mismatch("done_res", o_out_word.done_res, want_word.done_res);
                if (o_out_word.read_data !== want_word.read_data)
                    report_mismatch("read_data", o_out_word.read_data, want_word.read_data);
                if (o_out_word.rejected !== want_word.rejected)
                    report_mismatch("rejected", o_out_word.rejected, want_word.rejected);
            end
        end
    end

    // Main sequence
    initial begin
        // idle bus, unused op, a write start, requests while busy, spare registers
        add_word_row(i2cee_pkg::OP_TICK,  8'h00, 8'h00, 1'b0, 1'b1, LINES_IDLE);
        add_word_row(i2cee_pkg::OP_TICK,  8'hFF, 8'hFF, 1'b1, 1'b1, LINES_IDLE);
        add_word_row(OP_UNUSED,           8'hFF, 8'hFF, 1'b1, 1'b1, LINES_IDLE);
        add_word_row(i2cee_pkg::OP_WRITE, 8'hFF, 8'h00, 1'b0, 1'b1, JUST_STARTED);
        add_word_row(i2cee_pkg::OP_READ,  8'h00, 8'hFF, 1'b1, 1'b1, BUSY_REJECT);
        add_word_row(i2cee_pkg::OP_WRITE, 8'h55, 8'hAA, 1'b0, 1'b1, BUSY_REJECT);
        add_word_row(OP_UNUSED,           8'h00, 8'h00, 1'b0, 1'b1, JUST_STARTED);
        add_word_row(i2cee_pkg::OP_TICK,  8'h00, 8'h00, 1'b0, 1'b0, '0);
        add_word_row(i2cee_pkg::OP_TICK,  8'h00, 8'h00, 1'b1, 1'b0, '0);
        add_cfg_row(REG_SPARE_2, 16'hFFFF);
        add_word_row(i2cee_pkg::OP_TICK,  8'h00, 8'h00, 1'b0, 1'b0, '0);
        add_word_row(i2cee_pkg::OP_TICK,  8'h00, 8'h00, 1'b1, 1'b0, '0);
        add_cfg_row(REG_SPARE_3, 16'h0000);
        // short write recovery, taken at the stop of the directed write
        add_cfg_row(i2cee_pkg::REG_WRITE_RECOV, 16'd4);
        for (int i = 0; i < 10; i++)
            add_word_row(i2cee_pkg::OP_TICK, 8'h00, 8'h00, 1'(i), 1'b0, '0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 36;
        rx_idle_pct = 72;
        foreach (stim_rows[i]) begin
            if (stim_rows[i].is_cfg) begin
                write_reg(stim_rows[i].cfg_idx, stim_rows[i].cfg_val);
            end else begin
                send_word(stim_rows[i].word);
                row_want = advance_master(stim_rows[i].word);
                pending_levels.push_back(stim_rows[i].typed ? stim_rows[i].want : row_want);
                items_sent++;
            end
        end
        // finish the directed write, then a read on the reset read recovery
        drive_ticks(1'b0, 1'b0);
        run_transfer(i2cee_pkg::OP_READ, 1'b0, 1'b0);

        run_phase(36, 72);
        run_phase(72, 36);
        run_phase(0, 0);

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
